@@ hdl/trk_pkg.sv @@
`default_nettype none

package trk_pkg;

   // Block sizing.
   localparam int NUM_KEYS  = 256;
   localparam int MAX_FRAGS = 32;
   localparam int KEY_W     = $clog2(NUM_KEYS);
   localparam int FRAG_W    = $clog2(MAX_FRAGS);
   localparam int CNT_W     = 6;

   // Field widths of the channels.
   localparam int SLOT_KEY_W   = 16;
   localparam int FRAG_INDEX_W = 8;
   localparam int HANDLE_W     = 16;
   localparam int TIME_W       = 48;
   localparam int TIMEOUT_W    = 32;
   localparam int OUT_INDEX_W  = 5;

   // The shared subtractor is two bits wider than a timestamp so that the
   // signed age and the age minus the timeout both fit without overflow.
   localparam int ALU_W = TIME_W + 2;

   // Register port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REG_TIMEOUT = 0;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd10000;

   localparam int HSTORE_DEPTH = NUM_KEYS * MAX_FRAGS;

   typedef enum logic [1:0] {
      SLOT_EMPTY      = 2'd0,
      SLOT_ASSEMBLING = 2'd1,
      SLOT_DONE       = 2'd2,
      SLOT_REJECTED   = 2'd3
   } slot_state_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_LOOK,
      SEQ_AGE,
      SEQ_UPDATE,
      SEQ_PRIME,
      SEQ_EMIT
   } seq_state_type;

   typedef struct packed {
      slot_state_type         status;
      logic [TIME_W-1:0]      stamp;
      logic [MAX_FRAGS-1:0]   present;
      logic [CNT_W-1:0]       count;
      logic [CNT_W-1:0]       high;
      logic                   fin;
   } slot_rec_type;

   localparam int REC_W = $bits(slot_rec_type);

endpackage

`default_nettype wire

@@ hdl/trk_req_if.sv @@
`default_nettype none

interface trk_req_if;
   import trk_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [SLOT_KEY_W-1:0]   slot_key;
   logic [FRAG_INDEX_W-1:0] frag_index;
   logic                    is_final;
   logic [HANDLE_W-1:0]     payload_handle;
   logic [TIME_W-1:0]       now_ms;

   modport source (
      output valid, slot_key, frag_index, is_final, payload_handle, now_ms,
      input  ready
   );

   modport sink (
      input  valid, slot_key, frag_index, is_final, payload_handle, now_ms,
      output ready
   );

endinterface

`default_nettype wire

@@ hdl/trk_rsp_if.sv @@
`default_nettype none

interface trk_rsp_if;
   import trk_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [HANDLE_W-1:0]    out_handle;
   logic [OUT_INDEX_W-1:0] out_index;
   logic                   end_of_run;

   modport source (
      output valid, out_handle, out_index, end_of_run,
      input  ready
   );

   modport sink (
      input  valid, out_handle, out_index, end_of_run,
      output ready
   );

endinterface

`default_nettype wire

@@ hdl/trk_ram.sv @@
`default_nettype none

module trk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/trk_alu.sv @@
`default_nettype none

module trk_alu (
   input  wire [trk_pkg::ALU_W-1:0] opnd_a,
   input  wire [trk_pkg::ALU_W-1:0] opnd_b,
   output logic [trk_pkg::ALU_W-1:0] diff,
   output logic                      neg
);
   import trk_pkg::*;

   // One wide subtractor, shared by the age and the timeout compare.
   assign diff = opnd_a - opnd_b;
   assign neg  = diff[ALU_W-1];

endmodule

`default_nettype wire

@@ hdl/trk_ctrl.sv @@
`default_nettype none

module trk_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire [trk_pkg::TIMEOUT_W-1:0] timeout,
   trk_req_if.sink                      req,
   trk_rsp_if.source                    rsp
);
   import trk_pkg::*;

   seq_state_type state_ff, state_in;

   logic [KEY_W-1:0]    key_ff, key_in;
   logic [FRAG_W-1:0]   idx_ff, idx_in;
   logic                fin_ff, fin_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic                in_range_ff, in_range_in;
   logic [ALU_W-1:0]    age_ff, age_in;
   logic                expired_ff, expired_in;
   logic [FRAG_W-1:0]   emit_idx_ff, emit_idx_in;
   logic [CNT_W-1:0]    run_len_ff, run_len_in;
   logic [NUM_KEYS-1:0] slot_valid_ff, slot_valid_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0]    rsp_handle_ff, rsp_handle_in;
   logic [OUT_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                   rsp_end_ff, rsp_end_in;

   logic [KEY_W-1:0]        rec_rd_addr;
   logic [REC_W-1:0]        rec_rd_data;
   logic                    rec_wr_en;
   slot_rec_type            rec_wr_data;
   slot_rec_type            rec;
   logic [KEY_W+FRAG_W-1:0] hs_rd_addr;
   logic [KEY_W+FRAG_W-1:0] hs_wr_addr;
   logic [HANDLE_W-1:0]     hs_rd_data;
   logic                    hs_wr_en;

   logic [ALU_W-1:0] alu_a, alu_b, alu_diff;
   logic             alu_neg;

   logic [MAX_FRAGS-1:0] bit_vec;
   logic [CNT_W-1:0]     idx_p1, cnt_p1, high_new;
   logic                 grew, eff_empty, dup, reject, complete, load, last_emit;
   logic                 slot_valid;

   trk_ram #(.WIDTH(REC_W), .DEPTH(NUM_KEYS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (key_ff),
      .wr_data (rec_wr_data),
      .rd_addr (rec_rd_addr),
      .rd_data (rec_rd_data)
   );

   trk_ram #(.WIDTH(HANDLE_W), .DEPTH(HSTORE_DEPTH)) u_handle_ram (
      .clock   (clock),
      .wr_en   (hs_wr_en),
      .wr_addr (hs_wr_addr),
      .wr_data (handle_ff),
      .rd_addr (hs_rd_addr),
      .rd_data (hs_rd_data)
   );

   trk_alu u_alu (
      .opnd_a (alu_a),
      .opnd_b (alu_b),
      .diff   (alu_diff),
      .neg    (alu_neg)
   );

   // First pass: now - stamp. Second pass: age - timeout.
   assign alu_a = (state_ff == SEQ_LOOK) ? ALU_W'(now_ff) : age_ff;
   assign alu_b = (state_ff == SEQ_LOOK) ? ALU_W'(rec.stamp) : ALU_W'(timeout);

   assign rec        = slot_rec_type'(rec_rd_data);
   assign slot_valid = slot_valid_ff[key_ff];

   assign bit_vec   = MAX_FRAGS'(1) << idx_ff;
   assign idx_p1    = CNT_W'(idx_ff) + CNT_W'(1);
   assign cnt_p1    = rec.count + CNT_W'(1);
   assign grew      = idx_p1 > rec.high;
   assign high_new  = grew ? idx_p1 : rec.high;
   assign eff_empty = !slot_valid || (rec.status == SLOT_EMPTY) || expired_ff;
   assign dup       = |(rec.present & bit_vec);
   assign reject    = (fin_ff && rec.fin) || (grew && rec.fin) || (!grew && fin_ff);
   assign complete  = (fin_ff || rec.fin) && (cnt_p1 == high_new);

   assign load      = (state_ff == SEQ_EMIT) && (!rsp_valid_ff || rsp.ready);
   assign last_emit = (CNT_W'(emit_idx_ff) + CNT_W'(1)) == run_len_ff;

   assign rec_rd_addr = (state_ff == SEQ_IDLE) ? req.slot_key[KEY_W-1:0] : key_ff;
   assign hs_wr_addr  = {key_ff, idx_ff};
   assign hs_rd_addr  = {key_ff, load ? FRAG_W'(emit_idx_ff + FRAG_W'(1)) : emit_idx_ff};

   assign req.ready = (state_ff == SEQ_IDLE);

   always_comb begin
      state_in    = state_ff;
      key_in      = key_ff;
      idx_in      = idx_ff;
      fin_in      = fin_ff;
      handle_in   = handle_ff;
      now_in      = now_ff;
      in_range_in = in_range_ff;
      age_in      = age_ff;
      expired_in  = expired_ff;
      emit_idx_in = emit_idx_ff;
      run_len_in  = run_len_ff;
      rec_wr_en   = 1'b0;
      rec_wr_data = rec;
      hs_wr_en    = 1'b0;

      case (state_ff)
         SEQ_IDLE: begin
            if (req.valid) begin
               key_in      = req.slot_key[KEY_W-1:0];
               idx_in      = req.frag_index[FRAG_W-1:0];
               fin_in      = req.is_final;
               handle_in   = req.payload_handle;
               now_in      = req.now_ms;
               in_range_in = ({1'b0, req.slot_key} < (SLOT_KEY_W+1)'(NUM_KEYS)) &&
                             (req.frag_index < FRAG_INDEX_W'(MAX_FRAGS));
               state_in    = SEQ_LOOK;
            end
         end
         SEQ_LOOK: begin
            age_in   = alu_diff;
            state_in = SEQ_AGE;
         end
         SEQ_AGE: begin
            expired_in = !alu_neg;
            state_in   = SEQ_UPDATE;
         end
         SEQ_UPDATE: begin
            state_in    = SEQ_IDLE;
            emit_idx_in = '0;
            if (in_range_ff) begin
               if (eff_empty) begin
                  rec_wr_en = 1'b1;
                  hs_wr_en  = 1'b1;
                  rec_wr_data.stamp = now_ff;
                  if (fin_ff && (idx_ff == '0)) begin
                     // A lone first fragment marked final completes at once.
                     rec_wr_data.status  = SLOT_DONE;
                     rec_wr_data.present = '0;
                     rec_wr_data.count   = '0;
                     rec_wr_data.high    = '0;
                     rec_wr_data.fin     = 1'b0;
                     run_len_in = CNT_W'(1);
                     state_in   = SEQ_PRIME;
                  end else begin
                     rec_wr_data.status  = SLOT_ASSEMBLING;
                     rec_wr_data.present = bit_vec;
                     rec_wr_data.count   = CNT_W'(1);
                     rec_wr_data.high    = idx_p1;
                     rec_wr_data.fin     = fin_ff;
                  end
               end else if ((rec.status == SLOT_ASSEMBLING) && !dup) begin
                  rec_wr_en = 1'b1;
                  hs_wr_en  = 1'b1;
                  if (reject || complete) begin
                     rec_wr_data.status  = reject ? SLOT_REJECTED : SLOT_DONE;
                     rec_wr_data.stamp   = now_ff;
                     rec_wr_data.present = '0;
                     rec_wr_data.count   = '0;
                     rec_wr_data.high    = '0;
                     rec_wr_data.fin     = 1'b0;
                     if (!reject) begin
                        run_len_in = cnt_p1;
                        state_in   = SEQ_PRIME;
                     end
                  end else begin
                     rec_wr_data.present = rec.present | bit_vec;
                     rec_wr_data.count   = cnt_p1;
                     rec_wr_data.high    = high_new;
                     rec_wr_data.fin     = rec.fin | fin_ff;
                  end
               end
            end
         end
         SEQ_PRIME: begin
            state_in = SEQ_EMIT;
         end
         SEQ_EMIT: begin
            if (load) begin
               emit_idx_in = FRAG_W'(emit_idx_ff + FRAG_W'(1));
               if (last_emit) begin
                  state_in = SEQ_IDLE;
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (rec_wr_en) begin
         slot_valid_in[key_ff] = 1'b1;
      end
   end

   always_comb begin
      rsp_handle_in = rsp_handle_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_end_in    = rsp_end_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_handle_in = hs_rd_data;
         rsp_index_in  = OUT_INDEX_W'(emit_idx_ff);
         rsp_end_in    = last_emit;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_handle = rsp_handle_ff;
   assign rsp.out_index  = rsp_index_ff;
   assign rsp.end_of_run = rsp_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      fin_ff        <= fin_in;
      handle_ff     <= handle_in;
      now_ff        <= now_in;
      in_range_ff   <= in_range_in;
      age_ff        <= age_in;
      expired_ff    <= expired_in;
      emit_idx_ff   <= emit_idx_in;
      run_len_ff    <= run_len_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_end_ff    <= rsp_end_in;
   end

endmodule

`default_nettype wire

@@ hdl/fragment_reassembly_tracker.sv @@
`default_nettype none

// Channel    Direction  Handshake              Carries
// req_bus    in         valid / ready          one fragment transaction
// rsp_bus    out        valid / ready          one handle of a completed datagram
// csr_*      in / out   psel, penable, pready  timeout_ms register at byte address 0
//
// A fragment goes through slot record read, age subtract, timeout compare
// and record update, the middle two passes going through one shared subtractor.
// A completed datagram then sends its handles from the handle memory read
// port after a priming step, one handle per cycle while rsp_bus is not stalled.
// Reset clears the sequencer, the output register and one valid bit per slot;
// an invalid slot reads as empty, so no clearing pass runs after reset.
// A new fragment is accepted while the last handle of a run still waits.

module fragment_reassembly_tracker (
   input  wire                           clock,
   input  wire                           reset,
   trk_req_if.sink                       req_bus,
   trk_rsp_if.source                     rsp_bus,
   input  wire                           csr_psel,
   input  wire                           csr_penable,
   input  wire                           csr_pwrite,
   input  wire [trk_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire [trk_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [trk_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);
   import trk_pkg::*;

   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic                 csr_hit;
   logic                 csr_write;

   // Registers sit on 4-byte boundaries; the low two address bits are ignored.
   assign csr_hit   = csr_paddr[CSR_ADDR_W-1:2] == 1'(REG_TIMEOUT);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      timeout_in = timeout_ff;
      if (csr_write && csr_hit) begin
         timeout_in = csr_pwdata[TIMEOUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(timeout_ff) : '0;

   // The sequencer owns the slot records, handle store and shared subtractor. The
   // user changes the timeout only while idle; the block does not enforce this.
   trk_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .timeout (timeout_ff),
      .req     (req_bus),
      .rsp     (rsp_bus)
   );

   // Each fragment transaction occupies the sequencer, so accepts never come back to back.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("fragment accepted back to back");

   // No fragment is taken while a run of handles is still being sent.
   a_no_accept_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.end_of_run |-> !req_bus.ready)
      else $error("fragment accepted in the middle of a run");

   // Within a run the handles follow one per cycle in index order while rsp_bus takes them.
   a_run_in_order: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.end_of_run |=>
         rsp_bus.valid && (rsp_bus.out_index == $past(rsp_bus.out_index) + 5'd1))
      else $error("run of handles broken or out of order");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the fragment reassembly tracker.
//
// Fragment transactions are queued by the stimulus process and handed to the
// request channel by a clocked driver. A clocked monitor watches both
// channels. Every fragment accepted on the request channel runs through a
// behavioral copy of the slot bookkeeping kept in this file, and the handles
// of any datagram that completes are appended to a queue of handles due.
// Every transaction taken from the response channel is compared against the
// head of that queue.
//
// The run has four parts, each under its own timeout setting:
//   1. the reset timeout, with a short directed list of corner cases,
//   2. the largest timeout, with random interleaved datagrams over all keys,
//   3. a 40 ms timeout over a few keys, so that slots expire while assembling,
//   4. a zero timeout with falling timestamps, where only slots stamped in
//      the future survive, with no idle cycles on either channel.
// The timeout register is only written once the previous part has drained.

module testbench;
   import trk_pkg::*;

   // Fragment as it travels on the request channel.
   typedef struct {
      logic [SLOT_KEY_W-1:0]   key;
      logic [FRAG_INDEX_W-1:0] index;
      logic                    fin;
      logic [HANDLE_W-1:0]     handle;
      logic [TIME_W-1:0]       now;
   } frag_type;

   // One handle of a completed datagram as it should leave the block.
   typedef struct {
      logic [HANDLE_W-1:0]    handle;
      logic [OUT_INDEX_W-1:0] index;
      logic                   last;
   } handle_rec_type;

   localparam logic [CSR_ADDR_W-1:0] TIMEOUT_ADDR = CSR_ADDR_W'(4 * REG_TIMEOUT);

   // Cycles with no transaction anywhere before the run is declared hung.
   localparam int IDLE_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   trk_req_if req_bus ();
   trk_rsp_if rsp_bus ();

   fragment_reassembly_tracker i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the per-key slot bookkeeping and of the timeout register.
   logic [TIMEOUT_W-1:0] timeout_ms;
   slot_state_type       slot_state   [NUM_KEYS];
   logic [TIME_W-1:0]    slot_time    [NUM_KEYS];
   logic [MAX_FRAGS-1:0] slot_present [NUM_KEYS];
   logic [CNT_W-1:0]     slot_count   [NUM_KEYS];
   logic [CNT_W-1:0]     slot_high    [NUM_KEYS];
   logic                 slot_fin     [NUM_KEYS];
   logic [HANDLE_W-1:0]  slot_handles [NUM_KEYS][MAX_FRAGS];

   frag_type       frags_to_send [$];
   frag_type       staged [$];
   handle_rec_type handles_due [$];

   int unsigned frags_queued       = 0;
   int unsigned frags_accepted     = 0;
   int unsigned well_formed_sent   = 0;
   int unsigned handles_checked    = 0;
   int unsigned datagrams_done     = 0;
   int unsigned datagrams_rejected = 0;
   int unsigned mismatches         = 0;
   int unsigned idle_cycles        = 0;

   // When set, neither channel inserts idle cycles.
   logic steady = 1'b0;

   // Timestamp generator for random fragments.
   logic [TIME_W-1:0] clock_ms;
   int unsigned       ms_step    = 1;
   logic              ms_falling = 1'b0;

   // Closing a slot clears its bookkeeping and restamps it.
   task automatic retire_slot(input int unsigned k, input slot_state_type st,
                              input logic [TIME_W-1:0] ms);
      slot_state[k]   = st;
      slot_time[k]    = ms;
      slot_present[k] = '0;
      slot_count[k]   = '0;
      slot_high[k]    = '0;
      slot_fin[k]     = 1'b0;
   endtask

   // Apply one accepted fragment to the shadow slots and queue the handles
   // of a datagram that it completes.
   task automatic track_fragment(input frag_type f);
      int unsigned          k;
      int unsigned          n;
      int unsigned          cnt;
      int unsigned          hi;
      int unsigned          prev_hi;
      logic                 grew;
      logic                 prev_fin;
      longint               age;
      logic [MAX_FRAGS-1:0] bit_m;
      handle_rec_type       r;

      if (f.index >= MAX_FRAGS || f.key >= NUM_KEYS) return;
      k = 32'(f.key);

      // The age is signed: a slot stamped later than this fragment never
      // expires, however small the timeout.
      if (slot_state[k] != SLOT_EMPTY) begin
         age = $signed({16'd0, f.now}) - $signed({16'd0, slot_time[k]});
         if (age >= $signed({32'd0, timeout_ms})) slot_state[k] = SLOT_EMPTY;
      end

      bit_m = MAX_FRAGS'(1) << f.index;

      case (slot_state[k])
         SLOT_EMPTY: begin
            if (f.fin && f.index == 0) begin
               // A single fragment datagram finishes on arrival.
               r.handle = f.handle;
               r.index  = '0;
               r.last   = 1'b1;
               handles_due.push_back(r);
               retire_slot(k, SLOT_DONE, f.now);
               datagrams_done++;
            end else begin
               slot_state[k]              = SLOT_ASSEMBLING;
               slot_time[k]               = f.now;
               slot_handles[k][f.index]   = f.handle;
               slot_present[k]            = bit_m;
               slot_count[k]              = CNT_W'(1);
               slot_high[k]               = CNT_W'(f.index + 1);
               slot_fin[k]                = f.fin;
            end
         end
         SLOT_ASSEMBLING: begin
            if ((slot_present[k] & bit_m) != '0) return;
            slot_handles[k][f.index] = f.handle;
            slot_present[k]          = slot_present[k] | bit_m;
            cnt      = slot_count[k] + 1;
            prev_hi  = 32'(slot_high[k]);
            grew     = (f.index + 1) > prev_hi;
            hi       = grew ? f.index + 1 : prev_hi;
            prev_fin = slot_fin[k];

            if ((f.fin && prev_fin) || (grew && prev_fin) || (!grew && f.fin)) begin
               // Contradictory final markers poison the datagram.
               retire_slot(k, SLOT_REJECTED, f.now);
               datagrams_rejected++;
            end else if ((f.fin || prev_fin) && cnt == hi) begin
               for (n = 0; n < cnt; n++) begin
                  r.handle = slot_handles[k][n];
                  r.index  = OUT_INDEX_W'(n);
                  r.last   = (n == cnt - 1);
                  handles_due.push_back(r);
               end
               retire_slot(k, SLOT_DONE, f.now);
               datagrams_done++;
            end else begin
               slot_count[k] = CNT_W'(cnt);
               if (f.fin) slot_fin[k] = 1'b1;
               if (grew) slot_high[k] = CNT_W'(hi);
            end
         end
         default: begin
            // Done and rejected slots ignore everything until they expire.
         end
      endcase
   endtask

   // Request driver. A new fragment is presented only once the previous one
   // has been taken; valid is only updated at a clock edge.
   always @(posedge clock) begin
      frag_type outgoing;
      if (reset) begin
         req_bus.valid          <= 1'b0;
         req_bus.slot_key       <= '0;
         req_bus.frag_index     <= '0;
         req_bus.is_final       <= 1'b0;
         req_bus.payload_handle <= '0;
         req_bus.now_ms         <= '0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (frags_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 27)) begin
            outgoing = frags_to_send.pop_front();
            req_bus.slot_key       <= outgoing.key;
            req_bus.frag_index     <= outgoing.index;
            req_bus.is_final       <= outgoing.fin;
            req_bus.payload_handle <= outgoing.handle;
            req_bus.now_ms         <= outgoing.now;
            req_bus.valid          <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response backpressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 27);
      end
   end

   // Monitor. Both channels are sampled at the clock edge, so the values seen
   // are those that were set up before the edge.
   always @(posedge clock) begin
      frag_type       seen;
      handle_rec_type due;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (handles_due.size() == 0) begin
               $error("unexpected handle %h at index %0d", rsp_bus.out_handle,
                      rsp_bus.out_index);
               mismatches++;
            end else begin
               due = handles_due.pop_front();
               if (rsp_bus.out_handle !== due.handle) begin
                  $error("out_handle: expected %h, got %h", due.handle, rsp_bus.out_handle);
                  mismatches++;
               end
               if (rsp_bus.out_index !== due.index) begin
                  $error("out_index: expected %0d, got %0d", due.index, rsp_bus.out_index);
                  mismatches++;
               end
               if (rsp_bus.end_of_run !== due.last) begin
                  $error("end_of_run: expected %b, got %b", due.last, rsp_bus.end_of_run);
                  mismatches++;
               end
               handles_checked++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.key    = req_bus.slot_key;
            seen.index  = req_bus.frag_index;
            seen.fin    = req_bus.is_final;
            seen.handle = req_bus.payload_handle;
            seen.now    = req_bus.now_ms;
            track_fragment(seen);
            frags_accepted++;
         end
      end
   end

   // Watchdog: any transaction on any port counts as progress.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_psel && csr_penable && csr_pready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles,", IDLE_LIMIT);
            $display("%0d fragments unsent, %0d handles due",
                     frags_queued - frags_accepted, handles_due.size());
            $display("Mismatches found");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Write the timeout register, read it back, and update the shadow copy.
   task automatic set_timeout(input logic [TIMEOUT_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TIMEOUT_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      timeout_ms = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value) begin
         $error("timeout_ms: expected %h, got %h", value, csr_prdata);
         mismatches++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_at(input logic [SLOT_KEY_W-1:0] k, input logic [FRAG_INDEX_W-1:0] i,
                          input logic fn, input logic [HANDLE_W-1:0] h,
                          input logic [TIME_W-1:0] ms);
      frag_type f;
      f.key    = k;
      f.index  = i;
      f.fin    = fn;
      f.handle = h;
      f.now    = ms;
      frags_to_send.push_back(f);
      frags_queued++;
   endtask

   function automatic logic [TIME_W-1:0] next_ms();
      logic [TIME_W-1:0] t;
      t = clock_ms;
      if (ms_falling) clock_ms = clock_ms - $urandom_range(1, ms_step);
      else clock_ms = clock_ms + $urandom_range(0, ms_step);
      return t;
   endfunction

   // Append one datagram to the staging queue: indexes shuffled most of the
   // time, the final marker on the top index, and now and then a duplicate
   // or a flipped final marker so that the drop and poison paths get hit.
   task automatic build_datagram(input int unsigned key_max, input int unsigned big_pct);
      int unsigned key;
      int unsigned n;
      int unsigned j;
      int unsigned pick;
      int unsigned tmp;
      int unsigned base;
      int unsigned roll;
      int unsigned order [MAX_FRAGS];
      frag_type    f;

      key = ($urandom_range(0, 9) == 0) ? key_max : $urandom_range(0, key_max);
      n   = ($urandom_range(0, 99) < big_pct) ? MAX_FRAGS : $urandom_range(1, 6);
      for (j = 0; j < n; j++) order[j] = j;
      if ($urandom_range(0, 99) < 60) begin
         for (j = n - 1; j > 0; j--) begin
            pick        = $urandom_range(0, j);
            tmp         = order[j];
            order[j]    = order[pick];
            order[pick] = tmp;
         end
      end
      base = staged.size();
      for (j = 0; j < n; j++) begin
         f.key    = SLOT_KEY_W'(key);
         f.index  = FRAG_INDEX_W'(order[j]);
         f.fin    = (order[j] == n - 1);
         f.handle = HANDLE_W'($urandom_range(0, 65535));
         f.now    = '0;
         staged.push_back(f);
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         pick         = base + $urandom_range(0, n - 1);
         f            = staged[pick];
         f.fin        = !f.fin;
         staged[pick] = f;
      end else if (roll < 18) begin
         f        = staged[base + $urandom_range(0, n - 1)];
         f.handle = HANDLE_W'($urandom_range(0, 65535));
         staged.insert(base + $urandom_range(0, n), f);
      end
   endtask

   // Two datagrams interleaved at random, with out-of-range fragments sprinkled
   // in between. Only the fragments of the datagrams count toward the target.
   task automatic run_phase(input int unsigned target, input int unsigned key_max,
                            input int unsigned big_pct);
      int unsigned start;
      int unsigned na;
      int unsigned ia;
      int unsigned ib;
      frag_type    f;

      start = well_formed_sent;
      while (well_formed_sent - start < target) begin
         staged.delete();
         build_datagram(key_max, big_pct);
         na = staged.size();
         build_datagram(key_max, big_pct);
         ia = 0;
         ib = na;
         while (ia < na || ib < staged.size()) begin
            if ($urandom_range(0, 99) < 8) begin
               if ($urandom_range(0, 1) == 1) begin
                  send_at(SLOT_KEY_W'($urandom_range(NUM_KEYS, 65535)),
                          FRAG_INDEX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          HANDLE_W'($urandom_range(0, 65535)), next_ms());
               end else begin
                  send_at(SLOT_KEY_W'($urandom_range(0, NUM_KEYS - 1)),
                          FRAG_INDEX_W'($urandom_range(MAX_FRAGS, 255)),
                          1'($urandom_range(0, 1)),
                          HANDLE_W'($urandom_range(0, 65535)), next_ms());
               end
            end
            if (ib >= staged.size() || (ia < na && $urandom_range(0, 1) == 1)) begin
               f = staged[ia];
               ia++;
            end else begin
               f = staged[ib];
               ib++;
            end
            send_at(f.key, f.index, f.fin, f.handle, next_ms());
            well_formed_sent++;
         end
      end
   endtask

   // Hold off until every queued fragment has been taken and every handle has
   // come back. Fragments that complete nothing may still be in the slot
   // update, so the task waits that out before the block counts as idle.
   task automatic drain();
      do @(posedge clock);
      while (frags_accepted != frags_queued || handles_due.size() != 0);
      repeat (12) @(posedge clock);
   endtask

   initial begin
      int k;

      reset       <= 1'b1;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;

      for (k = 0; k < NUM_KEYS; k++) slot_state[k] = SLOT_EMPTY;
      timeout_ms = TIMEOUT_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed corner cases under the reset timeout.
      set_timeout(TIMEOUT_RESET);
      // A lone first fragment marked final completes at once; the slot then
      // ignores further fragments.
      send_at(16'd0, 8'd0, 1'b1, 16'hFFFF, 48'd0);
      send_at(16'd0, 8'd1, 1'b0, 16'h0000, 48'd1);
      // Keys and indexes out of range are dropped.
      send_at(16'hFFFF, 8'd0, 1'b1, 16'h1234, 48'd2);
      send_at(16'd256, 8'd0, 1'b1, 16'h5678, 48'd2);
      send_at(16'd1, 8'hFF, 1'b0, 16'h9ABC, 48'd3);
      send_at(16'd1, 8'd32, 1'b1, 16'hDEF0, 48'd3);
      // Out-of-order datagram on the top key with a duplicate in the middle.
      send_at(16'd255, 8'd2, 1'b1, 16'hA002, 48'd10);
      send_at(16'd255, 8'd0, 1'b0, 16'hA000, 48'd11);
      send_at(16'd255, 8'd0, 1'b0, 16'hBAD0, 48'd12);
      send_at(16'd255, 8'd1, 1'b0, 16'hA001, 48'd13);
      // Fragment above an already seen final: poisoned, and then ignored.
      send_at(16'd2, 8'd1, 1'b1, 16'h0201, 48'd20);
      send_at(16'd2, 8'd3, 1'b0, 16'h0203, 48'd21);
      send_at(16'd2, 8'd0, 1'b0, 16'h0200, 48'd22);
      // Second final fragment.
      send_at(16'd3, 8'd0, 1'b0, 16'h0300, 48'd30);
      send_at(16'd3, 8'd2, 1'b1, 16'h0302, 48'd31);
      send_at(16'd3, 8'd1, 1'b1, 16'h0301, 48'd32);
      // Final fragment below the highest index so far.
      send_at(16'd4, 8'd3, 1'b0, 16'h0403, 48'd40);
      send_at(16'd4, 8'd1, 1'b1, 16'h0401, 48'd41);
      // Age exactly at the timeout: the slot restarts from the second
      // fragment and completes with the third.
      send_at(16'd5, 8'd0, 1'b0, 16'h0500, 48'd100);
      send_at(16'd5, 8'd1, 1'b1, 16'h0501, 48'd10100);
      send_at(16'd5, 8'd0, 1'b0, 16'h0510, 48'd10101);
      // Slot stamped in the future: a negative age never expires.
      send_at(16'd6, 8'd0, 1'b0, 16'h0600, 48'hFFFF_FFFF_FFFF);
      send_at(16'd6, 8'd1, 1'b1, 16'h0601, 48'd0);
      drain();

      // Largest timeout: nothing expires within the phase, keys collide now
      // and then with finished slots.
      set_timeout(32'hFFFF_FFFF);
      clock_ms   = {1'b0, 15'($urandom_range(0, 32767)), 32'($urandom)};
      ms_step    = 20;
      ms_falling = 1'b0;
      run_phase(85, NUM_KEYS - 1, 6);
      drain();

      // Short timeout on a handful of keys, so slots expire part way through
      // assembly and finished keys get reused.
      set_timeout(32'd40);
      clock_ms = {1'b1, 15'd0, 32'($urandom)};
      ms_step  = 8;
      run_phase(85, 15, 3);
      drain();

      // Zero timeout with time running backward: each fragment is older than
      // the slot's stamp, so datagrams still complete. No idle cycles here.
      set_timeout(32'd0);
      steady     = 1'b1;
      clock_ms   = '1;
      ms_step    = 3;
      ms_falling = 1'b1;
      run_phase(50, NUM_KEYS - 1, 4);
      drain();

      $display("Sent %0d fragments (%0d in random datagrams);",
               frags_accepted, well_formed_sent);
      $display("%0d datagrams completed, %0d rejected.", datagrams_done, datagrams_rejected);
      $display("Checked %0d handles under timeouts of 10000, 4294967295, 40 and 0 ms.",
               handles_checked);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ fragment_reassembly_tracker.f @@
hdl/trk_pkg.sv
hdl/trk_req_if.sv
hdl/trk_rsp_if.sv
hdl/trk_ram.sv
hdl/trk_alu.sv
hdl/trk_ctrl.sv
hdl/fragment_reassembly_tracker.sv
tb/testbench.sv
